/* src/fps_pkg.sv */
package fps_pkg;

  localparam int POINTS      = 8;
  localparam int IDX_BITS    = 3;
  localparam int SAMPLE_BITS = 16;
  localparam int BIN_BITS    = 20;
  localparam int TW_BITS     = 17;
  localparam int PROD_BITS   = BIN_BITS + TW_BITS;
  localparam int SUM_BITS    = PROD_BITS + 1;
  localparam int WORD_BITS   = 2 * BIN_BITS;

  // Q2.15 twiddles W0..W3, with one stored as 32768
  localparam logic signed [TW_BITS-1:0] TW_RE [4] = '{
    17'sd32768, 17'sd23170, 17'sd0, -17'sd23170
  };
  localparam logic signed [TW_BITS-1:0] TW_IM [4] = '{
    17'sd0, -17'sd23170, -17'sd32768, -17'sd23170
  };
  localparam logic signed [SUM_BITS-1:0] RND_HALF = 38'sd16384;

  // write data select
  localparam logic [1:0] WR_SAMPLE = 2'd0;
  localparam logic [1:0] WR_SUM    = 2'd1;
  localparam logic [1:0] WR_DIFF   = 2'd2;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] sample_re;
    logic signed [SAMPLE_BITS-1:0] sample_im;
  } fps_in_t;

  typedef struct packed {
    logic signed [BIN_BITS-1:0] bin_re;
    logic signed [BIN_BITS-1:0] bin_im;
    logic                       bin_last;
  } fps_out_t;

  typedef struct packed {
    logic [IDX_BITS-1:0] raddr_a;
    logic [IDX_BITS-1:0] raddr_b;
    logic [1:0]          tw_sel;
    logic                mul_en;
    logic                tw_en;
    logic                wr_en;
    logic [IDX_BITS-1:0] waddr;
    logic [1:0]          wr_sel;
    logic                last;
  } fps_cmd_t;

endpackage

/* src/fps_ram.sv */
module fps_ram #(
  parameter int WIDTH = 40,
  parameter int DEPTH = 8
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

/* src/fps_datapath.sv */
module fps_datapath
  import fps_pkg::*;
(
  input  logic     clk,
  input  fps_cmd_t cmd,
  input  fps_in_t  sample_word,
  output fps_out_t bin_word
);

  logic [WORD_BITS-1:0] wdata;
  logic [WORD_BITS-1:0] rdata_a;
  logic [WORD_BITS-1:0] rdata_b;

  logic signed [BIN_BITS-1:0]  a_re, a_im, b_re, b_im;
  logic signed [BIN_BITS-1:0]  u_re, u_im, t_re, t_im;
  logic signed [PROD_BITS-1:0] p_rr, p_ii, p_ri, p_ir;
  logic signed [SUM_BITS-1:0]  sum_re, sum_im;
  logic signed [TW_BITS-1:0]   w_re, w_im;

  fps_ram #(
    .WIDTH (WORD_BITS),
    .DEPTH (POINTS)
  ) u_store (
    .clk     (clk),
    .wr_en   (cmd.wr_en),
    .waddr   (cmd.waddr),
    .wdata   (wdata),
    .raddr_a (cmd.raddr_a),
    .raddr_b (cmd.raddr_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  assign a_re = rdata_a[WORD_BITS-1:BIN_BITS];
  assign a_im = rdata_a[BIN_BITS-1:0];
  assign b_re = rdata_b[WORD_BITS-1:BIN_BITS];
  assign b_im = rdata_b[BIN_BITS-1:0];
  assign w_re = TW_RE[cmd.tw_sel];
  assign w_im = TW_IM[cmd.tw_sel];

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      u_re <= a_re;
      u_im <= a_im;
      p_rr <= b_re * w_re;
      p_ii <= b_im * w_im;
      p_ri <= b_re * w_im;
      p_ir <= b_im * w_re;
    end
  end

  // round half up, then shift right 15
  assign sum_re = SUM_BITS'(p_rr) - SUM_BITS'(p_ii) + RND_HALF;
  assign sum_im = SUM_BITS'(p_ri) + SUM_BITS'(p_ir) + RND_HALF;

  always_ff @(posedge clk) begin
    if (cmd.tw_en) begin
      t_re <= sum_re[BIN_BITS+14:15];
      t_im <= sum_im[BIN_BITS+14:15];
    end
  end

  always_comb begin
    case (cmd.wr_sel)
      WR_SAMPLE: wdata = {BIN_BITS'(sample_word.sample_re), BIN_BITS'(sample_word.sample_im)};
      WR_SUM:    wdata = {u_re + t_re, u_im + t_im};
      WR_DIFF:   wdata = {u_re - t_re, u_im - t_im};
      default:   wdata = {u_re - t_re, u_im - t_im};
    endcase
  end

  assign bin_word.bin_re   = a_re;
  assign bin_word.bin_im   = a_im;
  assign bin_word.bin_last = cmd.last;

endmodule

/* src/fps_ctrl.sv */
module fps_ctrl
  import fps_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     sample_valid,
  output logic     sample_ready,
  output logic     bin_valid,
  input  logic     bin_ready,
  output fps_cmd_t cmd
);

  localparam logic [2:0] S_FILL = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_TW   = 3'd3;
  localparam logic [2:0] S_WA   = 3'd4;
  localparam logic [2:0] S_WB   = 3'd5;
  localparam logic [2:0] S_ORD  = 3'd6;
  localparam logic [2:0] S_OVAL = 3'd7;

  logic [2:0]          state, state_next;
  logic [IDX_BITS-1:0] idx, idx_next;
  logic [1:0]          stage, stage_next;
  logic [1:0]          bf, bf_next;
  logic [IDX_BITS-1:0] addr_a, addr_b;
  logic [1:0]          tw_k;

  // butterfly pair and twiddle for this stage
  always_comb begin
    case (stage)
      2'd0: begin
        addr_a = {bf, 1'b0};
        addr_b = {bf, 1'b1};
        tw_k   = 2'd0;
      end
      2'd1: begin
        addr_a = {bf[1], 1'b0, bf[0]};
        addr_b = {bf[1], 1'b1, bf[0]};
        tw_k   = {bf[0], 1'b0};
      end
      default: begin
        addr_a = {1'b0, bf};
        addr_b = {1'b1, bf};
        tw_k   = bf;
      end
    endcase
  end

  assign sample_ready = (state == S_FILL);
  assign bin_valid    = (state == S_OVAL);

  always_comb begin
    cmd.raddr_a = (state == S_ORD || state == S_OVAL) ? idx : addr_a;
    cmd.raddr_b = addr_b;
    cmd.tw_sel  = tw_k;
    cmd.mul_en  = (state == S_MUL);
    cmd.tw_en   = (state == S_TW);
    cmd.last    = (idx == IDX_BITS'(POINTS - 1));
    case (state)
      S_FILL: begin
        // store bit-reversed so the transform runs in place
        cmd.wr_en  = sample_valid;
        cmd.waddr  = {idx[0], idx[1], idx[2]};
        cmd.wr_sel = WR_SAMPLE;
      end
      S_WA: begin
        cmd.wr_en  = 1'b1;
        cmd.waddr  = addr_a;
        cmd.wr_sel = WR_SUM;
      end
      S_WB: begin
        cmd.wr_en  = 1'b1;
        cmd.waddr  = addr_b;
        cmd.wr_sel = WR_DIFF;
      end
      default: begin
        cmd.wr_en  = 1'b0;
        cmd.waddr  = addr_a;
        cmd.wr_sel = WR_SUM;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    idx_next   = idx;
    stage_next = stage;
    bf_next    = bf;
    case (state)
      S_FILL: begin
        if (sample_valid) begin
          idx_next = idx + 1'b1;
          if (idx == IDX_BITS'(POINTS - 1)) begin
            state_next = S_RD;
            stage_next = 2'd0;
            bf_next    = 2'd0;
          end
        end
      end
      S_RD:  state_next = S_MUL;
      S_MUL: state_next = S_TW;
      S_TW:  state_next = S_WA;
      S_WA:  state_next = S_WB;
      S_WB: begin
        bf_next = bf + 1'b1;
        if (bf == 2'd3) begin
          if (stage == 2'd2) begin
            state_next = S_ORD;
          end else begin
            stage_next = stage + 1'b1;
            state_next = S_RD;
          end
        end else begin
          state_next = S_RD;
        end
      end
      S_ORD: state_next = S_OVAL;
      S_OVAL: begin
        if (bin_ready) begin
          idx_next   = idx + 1'b1;
          state_next = (idx == IDX_BITS'(POINTS - 1)) ? S_FILL : S_ORD;
        end
      end
      default: state_next = S_FILL;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_FILL;
      idx   <= '0;
      stage <= '0;
      bf    <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
      stage <= stage_next;
      bf    <= bf_next;
    end
  end

endmodule

/* src/fft_8_point_stream_unit.sv */
// Eight samples are taken, one a cycle, then the transform runs as twelve butterflies
// on one shared complex twiddle multiplier, each in the steps read, multiply, twiddle round,
// write sum and write difference. Each bin is read from the store (S_ORD) and then held
// valid until bin_ready is seen. No sample is taken until the last bin of the frame is out.
// Synchronous reset returns to sample collection with an empty frame; store contents
// are not cleared.
module fft_8_point_stream_unit
  import fps_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     sample_valid,
  output logic     sample_ready,
  input  fps_in_t  sample_word,
  output logic     bin_valid,
  input  logic     bin_ready,
  output fps_out_t bin_word
);

  fps_cmd_t cmd;

  fps_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .bin_valid    (bin_valid),
    .bin_ready    (bin_ready),
    .cmd          (cmd)
  );

  fps_datapath u_datapath (
    .clk         (clk),
    .cmd         (cmd),
    .sample_word (sample_word),
    .bin_word    (bin_word)
  );

endmodule
